FILE: src/q248alu_pkg.sv
package q248alu_pkg;

  // port widths fixed by the item format
  localparam int IO_WIDTH  = 32;
  localparam int CMD_WIDTH = 4;

  // default configuration of the datapath
  localparam int FRACTION_BITS_DEF = 8;
  localparam int WORD_WIDTH_DEF    = 32;

  // command codes
  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_LT  = 4'd4,
    CMD_GT  = 4'd5,
    CMD_LE  = 4'd6,
    CMD_GE  = 4'd7,
    CMD_EQ  = 4'd8,
    CMD_NE  = 4'd9,
    CMD_MIN = 4'd10,
    CMD_MAX = 4'd11,
    CMD_INC = 4'd12,
    CMD_DEC = 4'd13
  } cmd_t;

endpackage

FILE: src/q248alu_div_stage.sv
module q248alu_div_stage import q248alu_pkg::*; #(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF,
  parameter int DVD_WIDTH  = WORD_WIDTH_DEF + FRACTION_BITS_DEF,
  parameter int SIDE_WIDTH = WORD_WIDTH_DEF + 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  ena,
  input  logic                  in_vld,
  input  logic [WORD_WIDTH-1:0] in_rem,
  input  logic [DVD_WIDTH-1:0]  in_dvd,
  input  logic [WORD_WIDTH-1:0] in_dsr,
  input  logic [SIDE_WIDTH-1:0] in_side,
  output logic                  out_vld,
  output logic [WORD_WIDTH-1:0] out_rem,
  output logic [DVD_WIDTH-1:0]  out_dvd,
  output logic [WORD_WIDTH-1:0] out_dsr,
  output logic [SIDE_WIDTH-1:0] out_side
);

  logic [WORD_WIDTH:0]   shifted;
  logic [WORD_WIDTH+1:0] diff;
  logic                  borrow;

  // one restoring step: bring down the next dividend bit and try a subtract
  always_comb begin
    shifted = {in_rem, in_dvd[DVD_WIDTH-1]};
    diff    = {1'b0, shifted} - {2'b00, in_dsr};
    borrow  = diff[WORD_WIDTH+1];
  end

  // stage register, quotient bits shift in at the bottom of the dividend
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (ena) begin
      out_vld <= in_vld;
    end
    if (ena) begin
      out_rem  <= borrow ? shifted[WORD_WIDTH-1:0] : diff[WORD_WIDTH-1:0];
      out_dvd  <= {in_dvd[DVD_WIDTH-2:0], ~borrow};
      out_dsr  <= in_dsr;
      out_side <= in_side;
    end
  end

endmodule

FILE: src/fixed_point_q24_8_alu_unit.sv
// signed fixed-point alu, one transfer per cycle sustained while the output is not stalled
// items pass through the input register, the operate register, the divider stages and the output register
// the divider is a restoring array of one quotient bit per stage, which sets the depth
// all stages advance together whenever the output register is empty or being taken
// synchronous active-high rst clears all valid bits; payload registers are not reset
module fixed_point_q24_8_alu_unit import q248alu_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int WORD_WIDTH    = WORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [CMD_WIDTH-1:0]       command,
  input  logic signed [IO_WIDTH-1:0] operand_a,
  input  logic signed [IO_WIDTH-1:0] operand_b,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [IO_WIDTH-1:0] result,
  output logic                       compare_true,
  output logic                       divide_by_zero
);

  localparam int DW = WORD_WIDTH + FRACTION_BITS;
  localparam int SW = WORD_WIDTH + 4;
  localparam int PW = 2 * WORD_WIDTH;

  logic adv;

  // input register
  logic                         s0_vld;
  cmd_t                         s0_cmd;
  logic signed [WORD_WIDTH-1:0] s0_a;
  logic signed [WORD_WIDTH-1:0] s0_b;

  // decode and operate register
  logic                         s1_vld;
  logic signed [PW-1:0]         s1_prod;
  logic signed [WORD_WIDTH-1:0] s1_misc;
  logic                         s1_cmp;
  logic                         s1_dz;
  logic                         s1_div;
  logic                         s1_mul;
  logic                         s1_qneg;
  logic [DW-1:0]                s1_dvd;
  logic [WORD_WIDTH-1:0]        s1_dsr;

  logic signed [WORD_WIDTH-1:0] misc_next;
  logic                         cmp_next;
  logic [WORD_WIDTH-1:0]        a_mag;
  logic [WORD_WIDTH-1:0]        b_mag;
  logic signed [PW-1:0]         prod_shift;
  logic signed [WORD_WIDTH-1:0] misc_sel;

  // divider chain
  logic                  dv_vld  [DW+1];
  logic [WORD_WIDTH-1:0] dv_rem  [DW+1];
  logic [DW-1:0]         dv_dvd  [DW+1];
  logic [WORD_WIDTH-1:0] dv_dsr  [DW+1];
  logic [SW-1:0]         dv_side [DW+1];

  logic [WORD_WIDTH-1:0]        quo;
  logic signed [WORD_WIDTH-1:0] res_next;
  logic                         last_div;
  logic                         last_dz;
  logic                         last_qneg;
  logic                         last_cmp;
  logic signed [WORD_WIDTH-1:0] last_misc;
  logic signed [WORD_WIDTH-1:0] out_word;

  // whole pipeline moves when the output register is free
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (adv) begin
      s0_vld <= in_valid;
    end
    if (adv) begin
      s0_cmd <= cmd_t'(command);
      s0_a   <= operand_a[WORD_WIDTH-1:0];
      s0_b   <= operand_b[WORD_WIDTH-1:0];
    end
  end

  // simple operations and compares
  always_comb begin
    misc_next = s0_a;
    cmp_next  = 1'b0;
    case (s0_cmd)
      CMD_ADD: misc_next = s0_a + s0_b;
      CMD_SUB: misc_next = s0_a - s0_b;
      CMD_MUL: misc_next = '0;
      CMD_DIV: misc_next = '0;
      CMD_LT:  begin misc_next = '0; cmp_next = s0_a <  s0_b; end
      CMD_GT:  begin misc_next = '0; cmp_next = s0_a >  s0_b; end
      CMD_LE:  begin misc_next = '0; cmp_next = s0_a <= s0_b; end
      CMD_GE:  begin misc_next = '0; cmp_next = s0_a >= s0_b; end
      CMD_EQ:  begin misc_next = '0; cmp_next = s0_a == s0_b; end
      CMD_NE:  begin misc_next = '0; cmp_next = s0_a != s0_b; end
      CMD_MIN: misc_next = (s0_a < s0_b) ? s0_a : s0_b;
      CMD_MAX: misc_next = (s0_a > s0_b) ? s0_a : s0_b;
      CMD_INC: misc_next = s0_a + WORD_WIDTH'(1);
      CMD_DEC: misc_next = s0_a - WORD_WIDTH'(1);
      default: misc_next = s0_a;
    endcase
    a_mag = s0_a[WORD_WIDTH-1] ? WORD_WIDTH'(-s0_a) : WORD_WIDTH'(s0_a);
    b_mag = s0_b[WORD_WIDTH-1] ? WORD_WIDTH'(-s0_b) : WORD_WIDTH'(s0_b);
  end

  // operate register: full product and divider setup
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= s0_vld;
    end
    if (adv) begin
      s1_prod <= PW'(s0_a) * PW'(s0_b);
      s1_misc <= misc_next;
      s1_cmp  <= cmp_next;
      s1_div  <= (s0_cmd == CMD_DIV);
      s1_dz   <= (s0_cmd == CMD_DIV) && (s0_b == '0);
      s1_mul  <= (s0_cmd == CMD_MUL);
      s1_qneg <= s0_a[WORD_WIDTH-1] ^ s0_b[WORD_WIDTH-1];
      s1_dvd  <= DW'(a_mag) << FRACTION_BITS;
      s1_dsr  <= b_mag;
    end
  end

  // product scaling folds into the side data of the divider chain
  always_comb begin
    prod_shift = s1_prod >>> FRACTION_BITS;
    misc_sel   = s1_mul ? prod_shift[WORD_WIDTH-1:0] : s1_misc;
  end

  assign dv_vld[0]  = s1_vld;
  assign dv_rem[0]  = '0;
  assign dv_dvd[0]  = s1_dvd;
  assign dv_dsr[0]  = s1_dsr;
  assign dv_side[0] = {misc_sel, s1_cmp, s1_dz, s1_div, s1_qneg};

  // one quotient bit per stage, most significant first
  for (genvar i = 0; i < DW; i++) begin : g_div
    q248alu_div_stage #(
      .WORD_WIDTH (WORD_WIDTH),
      .DVD_WIDTH  (DW),
      .SIDE_WIDTH (SW)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .ena      (adv),
      .in_vld   (dv_vld[i]),
      .in_rem   (dv_rem[i]),
      .in_dvd   (dv_dvd[i]),
      .in_dsr   (dv_dsr[i]),
      .in_side  (dv_side[i]),
      .out_vld  (dv_vld[i+1]),
      .out_rem  (dv_rem[i+1]),
      .out_dvd  (dv_dvd[i+1]),
      .out_dsr  (dv_dsr[i+1]),
      .out_side (dv_side[i+1])
    );
  end

  // sign fixup and final selection
  always_comb begin
    {last_misc, last_cmp, last_dz, last_div, last_qneg} = dv_side[DW];
    quo = dv_dvd[DW][WORD_WIDTH-1:0];
    if (last_div && !last_dz) begin
      res_next = last_qneg ? WORD_WIDTH'(-quo) : WORD_WIDTH'(quo);
    end else begin
      res_next = last_misc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_vld[DW];
    end
    if (adv) begin
      out_word       <= res_next;
      compare_true   <= last_cmp;
      divide_by_zero <= last_dz;
    end
  end

  assign result = IO_WIDTH'(out_word);

endmodule

FILE: src/q248alu_checker.sv
module q248alu_checker import q248alu_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [IO_WIDTH-1:0] result,
  input logic                compare_true,
  input logic                divide_by_zero
);

  // a stalled result transfer holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result) && $stable(compare_true)
      && $stable(divide_by_zero))
    else $error("stalled result changed");

  // division by zero always reports a zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> result == '0)
    else $error("divide by zero with nonzero result");

  // true compare results carry a zero word and no error
  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && compare_true |-> result == '0 && !divide_by_zero)
    else $error("compare result with nonzero word or error");

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  // input is stalled only while a result waits
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

endmodule

bind fixed_point_q24_8_alu_unit q248alu_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .result         (result),
  .compare_true   (compare_true),
  .divide_by_zero (divide_by_zero)
);
